@@ rtl/bounded_universe_priority_set_core_macros.svh @@
// Assertion helpers included by the priority set core.
`ifndef BOUNDED_UNIVERSE_PRIORITY_SET_CORE_MACROS_SVH
`define BOUNDED_UNIVERSE_PRIORITY_SET_CORE_MACROS_SVH

`define BUPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define BUPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/bups_pkg.sv @@
`default_nettype none
package bups_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_SUCC   = 3'd2,
    ACT_PRED   = 3'd3,
    ACT_DELMIN = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_PAYRD,
    S_PAYOUT
  } state_e;

endpackage
`default_nettype wire

@@ rtl/bounded_universe_priority_set_core.sv @@
`default_nettype none
// Ordered key set over a universe of 2^KEY_BITS keys, each key with a payload word.
// Command channel: a command is transferred when start_i is high and busy_o is low.
// action_i selects insert, delete, successor, predecessor or delete-minimum.
// Result channel: done_o is high for exactly one cycle with status_o, found_key_o,
// found_payload_o and stored_count_o; the receiver cannot stall it.
// Presence is held as one bitmap word per cluster in a synchronous memory, payloads in
// a second memory, and a one-bit-per-cluster summary in flip-flops.
// Insert and delete read the key's bitmap word (S_READ), then update it and answer
// in S_EVAL. A search reads the probe's cluster word and, on a hit, the payload
// (S_PAYRD, S_PAYOUT); each further cluster visited costs another bitmap read.
// Delete-minimum runs a search from zero, then a delete. Unused action codes
// answer from idle. The bitmap memory read port, one word per access, paces the steps.
// After reset the block clears the bitmap memory, one word per cycle, holding busy_o
// high until all 2^(KEY_BITS/2) words are cleared. Payload memory is not cleared.
module bounded_universe_priority_set_core #(
  parameter int KEY_BITS  = 16,
  parameter int DATA_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [2:0]           action_i,
  input  wire logic [KEY_BITS-1:0]  key_i,
  input  wire logic [DATA_BITS-1:0] payload_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic [KEY_BITS-1:0]       found_key_o,
  output logic [DATA_BITS-1:0]      found_payload_o,
  output logic [KEY_BITS:0]         stored_count_o
);
  import bups_pkg::*;

  localparam int HI  = KEY_BITS / 2;
  localparam int LOW = KEY_BITS - HI;
  localparam int W   = 1 << LOW;
  localparam int C   = 1 << HI;
  localparam int U   = 1 << KEY_BITS;

  function automatic logic [LOW-1:0] word_first(input logic [W-1:0] v);
    logic [LOW-1:0] r;
    r = '0;
    for (int i = W - 1; i >= 0; i--) if (v[i]) r = LOW'(i);
    return r;
  endfunction

  function automatic logic [LOW-1:0] word_last(input logic [W-1:0] v);
    logic [LOW-1:0] r;
    r = '0;
    for (int i = 0; i < W; i++) if (v[i]) r = LOW'(i);
    return r;
  endfunction

  function automatic logic [HI-1:0] sum_first(input logic [C-1:0] v);
    logic [HI-1:0] r;
    r = '0;
    for (int i = C - 1; i >= 0; i--) if (v[i]) r = HI'(i);
    return r;
  endfunction

  function automatic logic [HI-1:0] sum_last(input logic [C-1:0] v);
    logic [HI-1:0] r;
    r = '0;
    for (int i = 0; i < C; i++) if (v[i]) r = HI'(i);
    return r;
  endfunction

  state_e state_q, state_d;
  logic [2:0]           act_q, act_d;
  logic                 dm_q, dm_d;
  logic [HI-1:0]        clu_q, clu_d;
  logic [LOW-1:0]       lo_q, lo_d;
  logic [KEY_BITS-1:0]  pa_q, pa_d;
  logic [DATA_BITS-1:0] data_q, data_d;
  logic [HI-1:0]        clr_q, clr_d;
  logic [KEY_BITS:0]    cnt_q, cnt_d;
  logic [C-1:0]         summary_q, summary_d;
  logic                 done_q, done_d;
  logic [1:0]           status_q, status_d;
  logic [KEY_BITS-1:0]  fkey_q, fkey_d;
  logic [DATA_BITS-1:0] fpay_q, fpay_d;

  logic [W-1:0]         word_mem [C];
  logic [DATA_BITS-1:0] pay_mem [U];
  logic [W-1:0]         word_rd_q;
  logic [DATA_BITS-1:0] pay_rd_q;
  logic                 word_we, pay_we;
  logic [HI-1:0]        word_wa;
  logic [W-1:0]         word_wd;

  logic                 accept, search_up, hit, bit_set, sum_any;
  logic [W-1:0]         bit_mask, mask_up, mask_dn, cand;
  logic [C-1:0]         sum_up, sum_dn;
  logic [LOW-1:0]       pos;
  logic [HI-1:0]        nc;

  assign accept    = start_i && (state_q == S_IDLE);
  assign search_up = (act_q == ACT_SUCC);
  assign bit_mask  = W'(1) << lo_q;
  assign bit_set   = |(word_rd_q & bit_mask);
  assign mask_up   = {W{1'b1}} << lo_q;
  assign mask_dn   = {W{1'b1}} >> (~lo_q);
  assign cand      = word_rd_q & (search_up ? mask_up : mask_dn);
  assign hit       = |cand;
  assign pos       = search_up ? word_first(cand) : word_last(cand);
  assign sum_up    = summary_q & ({C{1'b1}} << clu_q) & ~(C'(1) << clu_q);
  assign sum_dn    = summary_q & ~({C{1'b1}} << clu_q);
  assign sum_any   = search_up ? |sum_up : |sum_dn;
  assign nc        = search_up ? sum_first(sum_up) : sum_last(sum_dn);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == HI'(C - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept && action_i <= 3'(ACT_DELMIN)) state_d = S_READ;
      end
      S_READ:  state_d = S_EVAL;
      S_EVAL: begin
        if (act_q == ACT_INSERT || act_q == ACT_DELETE) state_d = S_IDLE;
        else if (hit) state_d = dm_q ? S_READ : S_PAYRD;
        else if (sum_any) state_d = S_READ;
        else state_d = S_IDLE;
      end
      S_PAYRD:  state_d = S_PAYOUT;
      S_PAYOUT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    act_d     = act_q;
    dm_d      = dm_q;
    clu_d     = clu_q;
    lo_d      = lo_q;
    pa_d      = pa_q;
    data_d    = data_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    summary_d = summary_q;
    done_d    = 1'b0;
    status_d  = status_q;
    fkey_d    = fkey_q;
    fpay_d    = fpay_q;
    word_we   = 1'b0;
    word_wa   = clu_q;
    word_wd   = '0;
    pay_we    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        word_we = 1'b1;
        word_wa = clr_q;
        clr_d   = clr_q + HI'(1);
      end
      S_IDLE: begin
        if (accept) begin
          data_d = payload_i;
          if (action_i == 3'(ACT_DELMIN)) begin
            act_d = ACT_SUCC;
            dm_d  = 1'b1;
            clu_d = '0;
            lo_d  = '0;
            pa_d  = '0;
          end else begin
            act_d = action_i;
            dm_d  = 1'b0;
            clu_d = key_i[KEY_BITS-1:LOW];
            lo_d  = key_i[LOW-1:0];
            pa_d  = key_i;
          end
          if (action_i > 3'(ACT_DELMIN)) begin
            done_d   = 1'b1;
            status_d = ST_MISS;
            fkey_d   = '0;
            fpay_d   = '0;
          end
        end
      end
      S_EVAL: begin
        if (act_q == ACT_INSERT) begin
          done_d = 1'b1;
          fkey_d = pa_q;
          if (bit_set) begin
            status_d = ST_DUP;
            fpay_d   = pay_rd_q;
          end else begin
            status_d         = ST_OK;
            fpay_d           = data_q;
            word_we          = 1'b1;
            word_wd          = word_rd_q | bit_mask;
            pay_we           = 1'b1;
            summary_d[clu_q] = 1'b1;
            cnt_d            = cnt_q + (KEY_BITS+1)'(1);
          end
        end else if (act_q == ACT_DELETE) begin
          done_d = 1'b1;
          fkey_d = pa_q;
          if (bit_set) begin
            status_d         = ST_OK;
            fpay_d           = pay_rd_q;
            word_we          = 1'b1;
            word_wd          = word_rd_q & ~bit_mask;
            summary_d[clu_q] = |(word_rd_q & ~bit_mask);
            cnt_d            = cnt_q - (KEY_BITS+1)'(1);
          end else begin
            status_d = ST_MISS;
            fpay_d   = '0;
          end
        end else if (hit) begin
          pa_d = {clu_q, pos};
          lo_d = pos;
          if (dm_q) act_d = ACT_DELETE;
        end else if (sum_any) begin
          clu_d = nc;
          lo_d  = search_up ? '0 : {LOW{1'b1}};
        end else begin
          done_d   = 1'b1;
          status_d = ST_MISS;
          fkey_d   = '0;
          fpay_d   = '0;
        end
      end
      S_PAYOUT: begin
        done_d   = 1'b1;
        status_d = ST_OK;
        fkey_d   = pa_q;
        fpay_d   = pay_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      act_q     <= '0;
      dm_q      <= 1'b0;
      clr_q     <= '0;
      cnt_q     <= '0;
      summary_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      dm_q      <= dm_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      summary_q <= summary_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clu_q    <= clu_d;
    lo_q     <= lo_d;
    pa_q     <= pa_d;
    data_q   <= data_d;
    status_q <= status_d;
    fkey_q   <= fkey_d;
    fpay_q   <= fpay_d;
  end

  always_ff @(posedge clk_i) begin
    if (word_we) word_mem[word_wa] <= word_wd;
    word_rd_q <= word_mem[clu_q];
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) pay_mem[pa_q] <= data_q;
    pay_rd_q <= pay_mem[pa_q];
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign found_key_o     = fkey_q;
  assign found_payload_o = fpay_q;
  assign stored_count_o  = cnt_q;

`include "bounded_universe_priority_set_core_macros.svh"

  `BUPS_ASSERT(a_no_result_in_clear, (state_q == S_CLEAR) |-> !done_o, "result during clear")
  `BUPS_ASSERT(a_dup_keeps_count, (done_o && status_o == ST_DUP) |-> $stable(cnt_q), "dup changed count")
  `BUPS_ASSERT(a_count_bound, cnt_q <= (KEY_BITS+1)'(U), "count beyond universe")
  `BUPS_ASSERT(a_empty_summary, (cnt_q == '0 && state_q == S_IDLE) |-> (summary_q == '0), "summary not empty")
  `BUPS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !done_o, "result in reset")

endmodule
`default_nettype wire

@@ bench/bounded_universe_priority_set_core_tb.sv @@
`default_nettype none
module bounded_universe_priority_set_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bups_pkg::*;

  class priority_set_scoreboard;
    bit          present [65536];
    logic [31:0] stored_payload [65536];
    int          cluster_fill [256];
    int          held;
    int          errors;
    logic [1:0]  exp_status [$];
    logic [15:0] exp_key [$];
    logic [31:0] exp_payload [$];
    logic [16:0] exp_count [$];

    function bit find_up(int k, output int res);
      int c;
      for (c = k >> 8; c < 256; c++) begin
        if (cluster_fill[c] != 0) begin
          for (int i = (c == (k >> 8)) ? k : (c << 8); i < ((c + 1) << 8); i++) begin
            if (present[i]) begin
              res = i;
              return 1;
            end
          end
        end
      end
      return 0;
    endfunction

    function bit find_down(int k, output int res);
      int c;
      for (c = k >> 8; c >= 0; c--) begin
        if (cluster_fill[c] != 0) begin
          for (int i = (c == (k >> 8)) ? k : ((c << 8) + 255); i >= (c << 8); i--) begin
            if (present[i]) begin
              res = i;
              return 1;
            end
          end
        end
      end
      return 0;
    endfunction

    function void drop(int k);
      present[k] = 0;
      cluster_fill[k >> 8]--;
      held--;
    endfunction

    function void note_command(logic [2:0] act, logic [15:0] k, logic [31:0] p);
      logic [1:0]  st;
      logic [15:0] fk;
      logic [31:0] fp;
      int          r;
      st = ST_MISS;
      fk = '0;
      fp = '0;
      case (act)
        ACT_INSERT: begin
          fk = k;
          if (present[k]) begin
            st = ST_DUP;
            fp = stored_payload[k];
          end else begin
            present[k] = 1;
            stored_payload[k] = p;
            cluster_fill[k >> 8]++;
            held++;
            st = ST_OK;
            fp = p;
          end
        end
        ACT_DELETE: begin
          fk = k;
          if (present[k]) begin
            fp = stored_payload[k];
            drop(k);
            st = ST_OK;
          end
        end
        ACT_SUCC: begin
          if (find_up(k, r)) begin
            st = ST_OK;
            fk = r;
            fp = stored_payload[r];
          end
        end
        ACT_PRED: begin
          if (find_down(k, r)) begin
            st = ST_OK;
            fk = r;
            fp = stored_payload[r];
          end
        end
        ACT_DELMIN: begin
          if (find_up(0, r)) begin
            st = ST_OK;
            fk = r;
            fp = stored_payload[r];
            drop(r);
          end
        end
        default: ;
      endcase
      exp_status.push_back(st);
      exp_key.push_back(fk);
      exp_payload.push_back(fp);
      exp_count.push_back(held[16:0]);
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] fk, logic [31:0] fp,
                               logic [16:0] cnt);
      logic [1:0]  es;
      logic [15:0] ek;
      logic [31:0] ep;
      logic [16:0] ec;
      if (exp_status.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
        return;
      end
      es = exp_status.pop_front();
      ek = exp_key.pop_front();
      ep = exp_payload.pop_front();
      ec = exp_count.pop_front();
      if (st !== es) begin
        $error("status expected %0d actual %0d", es, st);
        errors++;
      end
      if (fk !== ek) begin
        $error("found_key expected %0h actual %0h", ek, fk);
        errors++;
      end
      if (fp !== ep) begin
        $error("found_payload expected %0h actual %0h", ep, fp);
        errors++;
      end
      if (cnt !== ec) begin
        $error("stored_count expected %0d actual %0d", ec, cnt);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  action_i;
  logic [15:0] key_i;
  logic [31:0] payload_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] found_key_o;
  logic [31:0] found_payload_o;
  logic [16:0] stored_count_o;

  priority_set_scoreboard sb;
  int          idle_pct;
  logic [15:0] key_pool [$];

  bounded_universe_priority_set_core DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .key_i, .payload_i,
    .done_o, .status_o, .found_key_o, .found_payload_o, .stored_count_o
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("[bounded_universe_priority_set_core] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(status_o, found_key_o, found_payload_o, stored_count_o);
      if (start_i && !busy_o) sb.note_command(action_i, key_i, payload_i);
    end
  end

  task automatic send_command(logic [2:0] act, logic [15:0] k, logic [31:0] p);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start_i = 0;
      repeat (gap) @(negedge clk_i);
    end
    action_i = act;
    key_i = k;
    payload_i = p;
    start_i = 1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic random_command();
    int          pick;
    logic [2:0]  act;
    logic [15:0] k;
    pick = $urandom_range(99);
    if (pick < 35) act = ACT_INSERT;
    else if (pick < 55) act = ACT_DELETE;
    else if (pick < 70) act = ACT_SUCC;
    else if (pick < 85) act = ACT_PRED;
    else if (pick < 95) act = ACT_DELMIN;
    else act = 3'($urandom_range(5, 7));
    pick = $urandom_range(99);
    if (pick < 40 && key_pool.size() > 0)
      k = key_pool[$urandom_range(key_pool.size() - 1)];
    else if (pick < 70) k = 16'h3200 + 16'($urandom_range(1023));
    else k = 16'($urandom);
    if (act == ACT_INSERT) begin
      key_pool.push_back(k);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end
    send_command(act, k, $urandom);
  endtask

  initial begin
    int waited;
    sb = new();
    rst_ni = 0;
    start_i = 0;
    action_i = '0;
    key_i = '0;
    payload_i = '0;
    idle_pct = 15;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    send_command(ACT_DELMIN, 16'h0000, 32'h0);
    send_command(ACT_SUCC, 16'h0000, 32'h0);
    send_command(ACT_PRED, 16'hffff, 32'h0);
    send_command(ACT_DELETE, 16'h1234, 32'h0);
    send_command(ACT_INSERT, 16'h0000, 32'h0000_0000);
    send_command(ACT_INSERT, 16'hffff, 32'hffff_ffff);
    send_command(ACT_INSERT, 16'h8001, 32'ha5a5_5a5a);
    send_command(ACT_INSERT, 16'hffff, 32'h1111_1111);
    send_command(ACT_SUCC, 16'h0001, 32'hffff_ffff);
    send_command(ACT_PRED, 16'hfffe, 32'h0);
    send_command(ACT_SUCC, 16'hffff, 32'h0);
    send_command(ACT_PRED, 16'h0000, 32'h0);
    send_command(ACT_DELETE, 16'h0000, 32'h0);
    send_command(ACT_PRED, 16'h8000, 32'h0);
    send_command(ACT_DELETE, 16'h0000, 32'h0);
    send_command(3'd5, 16'hffff, 32'hffff_ffff);
    send_command(3'd6, 16'h0000, 32'h0);
    send_command(3'd7, 16'h5555, 32'h5555_5555);
    send_command(ACT_DELETE, 16'hffff, 32'h0);
    send_command(ACT_SUCC, 16'h8002, 32'h0);
    send_command(ACT_DELMIN, 16'h0000, 32'h0);
    send_command(ACT_DELMIN, 16'h0000, 32'h0);

    for (int i = 0; i < 1450; i++) begin
      if (i == 480) idle_pct = 49;
      if (i == 960) idle_pct = 0;
      random_command();
    end
    start_i = 0;

    waited = 0;
    while (sb.exp_status.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (600) @(posedge clk_i);
    if (sb.errors == 0 && sb.exp_status.size() == 0)
      $display("[bounded_universe_priority_set_core] OK");
    else
      $display("[bounded_universe_priority_set_core] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/bups_pkg.sv
rtl/bounded_universe_priority_set_core.sv
bench/bounded_universe_priority_set_core_tb.sv
